### hdl/signed_int_to_decimal_ascii_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII block
// Shared implication forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sitda assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sitda assertion failed");

`endif

### hdl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Constants and control types for the signed integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for 2^VALUE_BITS - 1.
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS   = 4 * NUM_DIGITS;
  localparam int STEP_BITS  = $clog2(VALUE_BITS + 1);
  localparam int LEFT_BITS  = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_BITS  = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

  typedef struct packed {
    logic load;
    logic dabble;
    logic next_digit;
    logic sel_sign;
  } cmd_t;

  typedef struct packed {
    logic dabble_done;
    logic top_zero;
    logic one_left;
    logic negative;
  } sts_t;

endpackage

### hdl/sitda_if.sv
// ----------------------------------------------------------------------------
// sitda_in_if / sitda_out_if
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
interface sitda_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sitda_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
  logic                               valid;
  logic                               ready;
  logic [sitda_pkg::CHAR_BITS-1:0]    ascii_char;
  logic                               last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

### hdl/sitda_datapath.sv
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude shifter, double-dabble BCD register and character formatting.
// ----------------------------------------------------------------------------
module sitda_datapath (
  input  logic                                    clk_i,
  input  sitda_pkg::cmd_t                         cmd_i,
  output sitda_pkg::sts_t                         sts_o,
  input  logic signed [sitda_pkg::VALUE_BITS-1:0] value_i,
  output logic [sitda_pkg::CHAR_BITS-1:0]         ascii_char_o,
  output logic                                    last_o
);

  logic [sitda_pkg::VALUE_BITS-1:0] mag_q, mag_d, mag_load;
  logic [sitda_pkg::BCD_BITS-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [sitda_pkg::STEP_BITS-1:0]  cnt_q, cnt_d;
  logic [sitda_pkg::LEFT_BITS-1:0]  left_q, left_d;
  logic                             neg_q, neg_d;
  logic [3:0]                       top_digit;

  assign mag_load = value_i[sitda_pkg::VALUE_BITS-1]
                    ? (~value_i + sitda_pkg::VALUE_BITS'(1)) : value_i;

  always_comb begin
    logic [3:0] dig;
    for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
      dig = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
    end
  end

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    left_d = left_q;
    neg_d  = neg_q;
    if (cmd_i.load) begin
      mag_d  = mag_load;
      bcd_d  = '0;
      cnt_d  = sitda_pkg::STEP_BITS'(sitda_pkg::VALUE_BITS);
      left_d = sitda_pkg::LEFT_BITS'(sitda_pkg::NUM_DIGITS);
      neg_d  = value_i[sitda_pkg::VALUE_BITS-1];
    end else if (cmd_i.dabble) begin
      bcd_d = {bcd_adj[sitda_pkg::BCD_BITS-2:0], mag_q[sitda_pkg::VALUE_BITS-1]};
      mag_d = {mag_q[sitda_pkg::VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - sitda_pkg::STEP_BITS'(1);
    end else if (cmd_i.next_digit) begin
      bcd_d  = {bcd_q[sitda_pkg::BCD_BITS-5:0], 4'd0};
      left_d = left_q - sitda_pkg::LEFT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    left_q <= left_d;
    neg_q  <= neg_d;
  end

  assign top_digit = bcd_q[sitda_pkg::BCD_BITS-1 -: 4];

  assign sts_o.dabble_done = (cnt_q == sitda_pkg::STEP_BITS'(1));
  assign sts_o.top_zero    = (top_digit == 4'd0);
  assign sts_o.one_left    = (left_q == sitda_pkg::LEFT_BITS'(1));
  assign sts_o.negative    = neg_q;

  assign ascii_char_o = cmd_i.sel_sign ? sitda_pkg::ASCII_MINUS
                                       : (sitda_pkg::ASCII_ZERO + {2'b00, top_digit});
  assign last_o       = !cmd_i.sel_sign && sts_o.one_left;

endmodule

### hdl/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: load, binary-to-BCD steps, leading-zero skip, character beats.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sitda_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sitda_pkg::cmd_t cmd_o,
  input  sitda_pkg::sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.dabble_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.next_digit = 1'b1;
        end else begin
          state_d = sts_i.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (out_ready_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.next_digit = 1'b1;
          if (sts_i.one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SITDA_ASSERT_NEXT(a_accept_starts_conv, in_valid_i && in_ready_o, state_q == ST_CONV)
  `SITDA_ASSERT_NEXT(a_conv_ends_in_skip, (state_q == ST_CONV) && sts_i.dabble_done,
                     state_q == ST_SKIP)
  `SITDA_ASSERT_SAME(a_sign_only_negative, state_q == ST_SIGN, sts_i.negative)
  `SITDA_ASSERT_NEXT(a_last_beat_to_idle,
                     (state_q == ST_EMIT) && out_ready_i && sts_i.one_left,
                     state_q == ST_IDLE)

endmodule

### hdl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to its decimal ASCII text, one character a beat.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                 Beat
// in_i     in   value (VALUE_BITS, s)   one integer
// out_o    out  ascii_char (6), last    one character, last on the final one
//
// An item passes through an accept while idle, the double-dabble steps in the
// sequencer, the leading-zero skip and the digit beats, and one more beat for
// a minus sign when the value is negative.
// Output stalls lengthen an item; the input is taken only when idle.
// Reset clears the sequencer state only.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sitda_in_if.sink    in_i,
  sitda_out_if.source out_o
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sitda_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (in_i.value),
    .ascii_char_o (out_o.ascii_char),
    .last_o       (out_o.last)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed integer to decimal ASCII converter.
// Integers go in on the value channel. Each character beat that comes out is
// compared with text typed in where a directed row gives it, and with text
// computed by a local decimal formatter for all other values. Random traffic
// runs in phases that vary sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF    = 5;
  localparam int RESET_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int TAIL_CYCLES = 60;
  localparam int STALL_LIMIT = 3000;

  typedef logic [sitda_pkg::VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic [sitda_pkg::CHAR_BITS-1:0] ascii_char;
    logic                            last;
  } char_beat_t;

  typedef struct {
    value_t value;
    string  text;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;

  sitda_in_if  in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  char_beat_t    expected_chars [$];
  string         pending_texts [$];
  directed_row_t directed_rows [16];
  int            error_count;
  int            quiet_cycles;
  int            send_idle_pct;
  int            recv_stall_pct;

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  function automatic void push_decimal_text(input value_t v);
    value_t     mag;
    logic [3:0] digits [$];
    logic [3:0] d;
    char_beat_t beat;
    mag = v[sitda_pkg::VALUE_BITS-1] ? -v : v;
    do begin
      digits.push_back(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[sitda_pkg::VALUE_BITS-1]) begin
      beat.ascii_char = sitda_pkg::ASCII_MINUS;
      beat.last = 1'b0;
      expected_chars.push_back(beat);
    end
    while (digits.size() > 0) begin
      d = digits.pop_back();
      beat.ascii_char = sitda_pkg::ASCII_ZERO + sitda_pkg::CHAR_BITS'(d);
      beat.last = (digits.size() == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic void push_typed_text(input string text);
    char_beat_t beat;
    byte        ch;
    for (int i = 0; i < text.len(); i++) begin
      ch = text[i];
      beat.ascii_char = ch[sitda_pkg::CHAR_BITS-1:0];
      beat.last = (i == text.len() - 1);
      expected_chars.push_back(beat);
    end
  endfunction

  function automatic value_t random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    int              ndig;
    case ($urandom_range(0, 7))
      0, 1: return value_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(sitda_pkg::VALUE_BITS-1){1'b0}}};
          1: return {1'b0, {(sitda_pkg::VALUE_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        ndig = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = lo + ($urandom % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1) return -value_t'(mag);
        return value_t'(mag);
      end
    endcase
  endfunction

  task automatic send_value(input value_t v, input string text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    pending_texts.push_back(text);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i);
    while (expected_chars.size() != 0 || pending_texts.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    char_beat_t want;
    string      text;
    logic       in_fire;
    logic       out_fire;
    if (rst_ni) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire) begin
        text = pending_texts.pop_front();
        if (text.len() > 0) begin
          push_typed_text(text);
        end else begin
          push_decimal_text(in_ch.value);
        end
      end
      if (out_fire) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat ascii_char=%0d last=%0b", $time,
                   out_ch.ascii_char, out_ch.last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.ascii_char !== want.ascii_char) begin
            $display("%0t: ascii_char expected %0d actual %0d", $time,
                     want.ascii_char, out_ch.ascii_char);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last,
                     out_ch.last);
            error_count++;
          end
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    error_count    = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    directed_rows = '{
      '{value_t'(0),            "0"},
      '{value_t'(1),            "1"},
      '{value_t'(-1),           "-1"},
      '{value_t'(9),            "9"},
      '{value_t'(10),           "10"},
      '{value_t'(-10),          "-10"},
      '{value_t'(99),           "99"},
      '{value_t'(100),          "100"},
      '{value_t'(2147483647),   "2147483647"},
      '{value_t'(-2147483647),  "-2147483647"},
      '{32'h8000_0000,          "-2147483648"},
      '{value_t'(1000000000),   "1000000000"},
      '{value_t'(-999999999),   "-999999999"},
      '{32'h5555_5555,          ""},
      '{32'hAAAA_AAAA,          ""},
      '{value_t'(123456789),    ""}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value, directed_rows[i].text);
    end
    wait_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
      wait_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/sitda_pkg.sv
hdl/sitda_if.sv
hdl/sitda_datapath.sv
hdl/sitda_ctrl.sv
hdl/signed_int_to_decimal_ascii_top.sv
tb/tb_top.sv
